// ----- design/chs_pkg.sv -----
package chs_pkg;

  // Identifier width and result slot width are fixed by the interface
  localparam int ID_W       = 20;
  localparam int SLOT_OUT_W = 8;

  // Bucket hash: remainder is built this many identifier bits per cycle
  localparam int STEP_BITS = 4;
  localparam int DIV_STEPS = ID_W / STEP_BITS;

  // Request kinds; code 3 is unused and changes nothing
  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

endpackage

// ----- design/chs_bucket_mod.sv -----
module chs_bucket_mod
  import chs_pkg::*;
#(
  parameter int BUCKETS = 64,
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [ID_W-1:0] id,
  output logic            done,
  output logic [BW-1:0]   bucket
);

  localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);
  localparam logic [BW:0] MODULUS = (BW + 1)'(BUCKETS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [ID_W-1:0]  shreg;
  logic [ID_W-1:0]  shreg_next;
  logic [BW-1:0]    rem_next;

  // Restoring remainder: shift in the next identifier bits, subtract when over
  always_comb begin
    logic [BW:0] trial;
    logic [BW-1:0] r;
    logic [ID_W-1:0] sh;
    r = bucket;
    sh = shreg;
    trial = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial = {r, sh[ID_W-1]};
      sh = {sh[ID_W-2:0], 1'b0};
      if (trial >= MODULUS) begin
        trial = trial - MODULUS;
      end
      r = trial[BW-1:0];
    end
    rem_next = r;
    shreg_next = sh;
  end

  // Advance the remainder one digit group per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        shreg  <= id;
        bucket <= '0;
      end else if (busy) begin
        shreg  <= shreg_next;
        bucket <= rem_next;
        cnt    <= cnt + CNT_W'(1);
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/chained_hash_set_insert_lookup_core.sv -----
// Sequence: a lookup or insert runs the remainder unit, reads the bucket head, then
// fetches and compares each entry in the chain until the walk stops at a compare or at a
// link check, and then loads the result. Clear and the unused kind go straight to the
// result. Throughput: a new request is taken the cycle after the previous result has
// been loaded into the output register.
// Reset: synchronous; a pass over every bucket zeroes the bucket heads with in_ready low.
module chained_hash_set_insert_lookup_core
  import chs_pkg::*;
#(
  parameter int BUCKETS = 64,
  parameter int ENTRIES = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            kind,
  input  logic [ID_W-1:0]       cell_id,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  found,
  output logic [SLOT_OUT_W-1:0] entry_slot,
  output logic                  marked_in_use,
  output logic                  table_full
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [BW-1:0] LAST_BUCKET = BW'(BUCKETS - 1);
  localparam logic [CW-1:0] POOL_SIZE = CW'(ENTRIES);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_FETCH,
    S_CMP,
    S_RESP
  } state_t;

  state_t state;

  // Table storage; an entry is live only if its slot is below slots_taken
  logic [SW-1:0]   bucket_head [BUCKETS];
  logic [ID_W-1:0] ent_key     [ENTRIES];
  logic [SW:0]     ent_link    [ENTRIES];
  logic [BW-1:0]   ent_bkt     [ENTRIES];
  logic            ent_mark    [ENTRIES];

  logic [CW-1:0]   slots_taken;
  logic [BW-1:0]   init_idx;
  kind_t           op;
  logic [ID_W-1:0] key;
  logic [SW-1:0]   cur;
  logic            cur_v;
  logic            first;
  logic [SW-1:0]   head_q;
  logic [ID_W-1:0] key_q;
  logic [SW:0]     link_q;
  logic [BW-1:0]   bkt_q;
  logic            mark_q;
  logic            res_found;
  logic [SW-1:0]   res_slot;
  logic            res_mark;
  logic            res_full;

  logic            accept;
  logic            hash_done;
  logic [BW-1:0]   bucket;
  logic [SW-1:0]   cur_sel;
  logic            curv_sel;
  logic            fetch_miss;
  logic            fetch_rd;
  logic            cmp_miss;
  logic            cmp_hit;
  logic            miss;
  logic            is_ins;
  logic            room;
  logic            do_alloc;
  logic            do_mark;
  logic [SW-1:0]   new_slot;
  logic            head_we;
  logic [BW-1:0]   head_waddr;
  logic [SW-1:0]   head_wdata;
  logic            mark_we;
  logic [SW-1:0]   mark_waddr;
  logic            mark_wdata;
  logic [SW+SLOT_OUT_W-1:0] slot_wide;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Bucket index: identifier modulo BUCKETS, STEP_BITS identifier bits per cycle
  chs_bucket_mod #(
    .BUCKETS(BUCKETS)
  ) u_bucket_mod (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .id    (cell_id),
    .done  (hash_done),
    .bucket(bucket)
  );

  // Chain walk decisions
  assign cur_sel    = first ? head_q : cur;
  assign curv_sel   = first || cur_v;
  assign fetch_miss = (state == S_FETCH) && (!curv_sel || (CW'(cur_sel) >= slots_taken));
  assign fetch_rd   = (state == S_FETCH) && !fetch_miss;
  assign cmp_miss   = (state == S_CMP) && (bkt_q != bucket);
  assign cmp_hit    = (state == S_CMP) && !cmp_miss && (key_q == key);
  assign miss       = fetch_miss || cmp_miss;
  assign is_ins     = (op == KIND_INSERT);
  assign room       = (slots_taken != POOL_SIZE);
  assign do_alloc   = miss && is_ins && room;
  assign do_mark    = cmp_hit && is_ins;
  assign new_slot   = slots_taken[SW-1:0];
  assign slot_wide  = {{SLOT_OUT_W{1'b0}}, res_slot};

  // Bucket head port: zero during the reset pass, new chain head on allocation
  assign head_we    = (state == S_INIT) || do_alloc;
  assign head_waddr = (state == S_INIT) ? init_idx : bucket;
  assign head_wdata = (state == S_INIT) ? '0 : new_slot;

  assign mark_we    = do_alloc || do_mark;
  assign mark_waddr = do_alloc ? new_slot : cur;
  assign mark_wdata = !do_alloc;

  always_ff @(posedge clk) begin
    if (head_we) begin
      bucket_head[head_waddr] <= head_wdata;
    end
    if (state == S_HEAD) begin
      head_q <= bucket_head[bucket];
    end
  end

  // Link a new entry in front of the old head; the link is live only if the
  // old head passed its check (the miss came after the first compare)
  always_ff @(posedge clk) begin
    if (do_alloc) begin
      ent_key[new_slot]  <= key;
      ent_link[new_slot] <= {!first, head_q};
      ent_bkt[new_slot]  <= bucket;
    end
    if (fetch_rd) begin
      key_q  <= ent_key[cur_sel];
      link_q <= ent_link[cur_sel];
      bkt_q  <= ent_bkt[cur_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      ent_mark[mark_waddr] <= mark_wdata;
    end
    if (fetch_rd) begin
      mark_q <= ent_mark[cur_sel];
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      init_idx    <= '0;
      slots_taken <= '0;
      out_valid   <= 1'b0;
      first       <= 1'b0;
      cur_v       <= 1'b0;
    end else begin
      // Drop a taken result; the response state reloads it on its own
      if (out_valid && out_ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          init_idx <= init_idx + BW'(1);
          if (init_idx == LAST_BUCKET) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op        <= kind_t'(kind);
            key       <= cell_id;
            res_found <= 1'b0;
            res_slot  <= '0;
            res_mark  <= 1'b0;
            res_full  <= 1'b0;
            unique case (kind_t'(kind))
              KIND_LOOKUP, KIND_INSERT: state <= S_HASH;
              KIND_CLEAR: begin
                slots_taken <= '0;
                state       <= S_RESP;
              end
              default: state <= S_RESP;
            endcase
          end
        end
        S_HASH: begin
          if (hash_done) begin
            state <= S_HEAD;
          end
        end
        S_HEAD: begin
          first <= 1'b1;
          state <= S_FETCH;
        end
        S_FETCH: begin
          if (fetch_miss) begin
            state <= S_RESP;
          end else begin
            cur   <= cur_sel;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (cmp_miss) begin
            state <= S_RESP;
          end else if (cmp_hit) begin
            res_found <= 1'b1;
            res_slot  <= cur;
            res_mark  <= is_ins ? 1'b1 : mark_q;
            state     <= S_RESP;
          end else begin
            cur   <= link_q[SW-1:0];
            cur_v <= link_q[SW];
            first <= 1'b0;
            state <= S_FETCH;
          end
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            found         <= res_found;
            entry_slot    <= slot_wide[SLOT_OUT_W-1:0];
            marked_in_use <= res_mark;
            table_full    <= res_full;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // Allocate a slot or flag a full pool on an insert that missed
      if (miss && is_ins) begin
        if (room) begin
          res_slot    <= new_slot;
          slots_taken <= slots_taken + CW'(1);
        end else begin
          res_full <= 1'b1;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_taken_bound: assert property (@(posedge clk) disable iff (rst)
    slots_taken <= POOL_SIZE)
    else $error("pool count beyond pool size");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> !found && !marked_in_use && (entry_slot == '0))
    else $error("full pool result carries an entry");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && (kind == KIND_CLEAR) |=> (slots_taken == '0))
    else $error("clear left pool slots taken");

  a_chain_bucket: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) && !first |-> (bkt_q == bucket))
    else $error("chain link leads out of its bucket");

  a_link_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) && !first && cur_v |-> (CW'(cur) < slots_taken))
    else $error("chain link points at an unallocated slot");
`endif

endmodule
